[hw/rtl/lisr_pkg.sv]
// lisr_pkg: constants, item kinds, register indexes and control structs
// shared by the linear image sensor readout block; no dependencies
package lisr_pkg;

    localparam int PIXELS      = 2048;
    localparam int SAMPLE_BITS = 14;

    localparam int PIX_AW    = $clog2(PIXELS);
    localparam int DVD_W     = SAMPLE_BITS + 1;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = (PIX_AW > $clog2(DIV_STEPS)) ? PIX_AW : $clog2(DIV_STEPS);
    localparam int TC_W      = $clog2(PIXELS + 257);

    localparam int KIND_W  = 3;
    localparam int SMP_W   = 14;
    localparam int IDX_W   = 11;
    localparam int HC_W    = 16;
    localparam int IC_W    = 8;
    localparam int SKIP_W  = 8;
    localparam int TO_W    = 10;
    localparam int PIXV_W  = 16;
    localparam int REM_W   = IC_W;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;
    localparam int IN_DW   = 32;
    localparam int OUT_DW  = 24;

    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TRIG  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    localparam logic [CFG_AW-1:0] CFG_START_HC = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_INT_CNT  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SKIP     = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT  = 2'd3;

    localparam logic [HC_W-1:0]   RST_START_HC = 16'd100;
    localparam logic [IC_W-1:0]   RST_INT_CNT  = 8'd1;
    localparam logic [SKIP_W-1:0] RST_SKIP     = 8'd0;
    localparam logic [TO_W-1:0]   RST_TIMEOUT  = 10'd1000;

    localparam logic [SMP_W-1:0] SAMPLE_MASK = SMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [DVD_W-1:0] FULL_SCALE  = DVD_W'(1 << SAMPLE_BITS);

    typedef struct packed {
        logic accept;
        logic cnt_clr;
        logic cnt_inc;
        logic sweep_we;
        logic div_step;
        logic rmw_we;
        logic take_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic trig_rmw;
        logic sweep_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/lisr_ram.sv]
// lisr_ram: generic single write port, single read port ram with registered read
// no dependencies
module lisr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/lisr_ctrl.sv]
// lisr_ctrl: sequencer for the readout block, issues commands to lisr_dp
// depends on lisr_pkg
module lisr_ctrl
    import lisr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_ready,
    input  t_sts              i_sts,
    output t_cmd              o_cmd
);

    localparam logic [2:0] S_BOOT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_BOOT, S_CLEAR: begin
                o_cmd.sweep_we = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = (r_state == S_BOOT) ? S_IDLE : S_EMIT;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    unique case (i_kind)
                        KIND_CLEAR: n_state = S_CLEAR;
                        KIND_READ:  n_state = S_READ;
                        KIND_TRIG:  n_state = i_sts.trig_rmw ? S_DIV : S_EMIT;
                        default:    n_state = S_EMIT;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.take_rd = 1'b1;
                n_state = S_EMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.rmw_we = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lisr_dp.sv]
// lisr_dp: status registers, configuration, divider, pixel store and result register
// depends on lisr_pkg and lisr_ram
module lisr_dp
    import lisr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SMP_W-1:0]  i_sample,
    input  logic [IDX_W-1:0]  i_pixel_index,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [OUT_DW-1:0] o_out_data
);

    logic [HC_W-1:0]   r_start_hc;
    logic [IC_W-1:0]   r_int_cnt;
    logic [SKIP_W-1:0] r_skip;
    logic [TO_W-1:0]   r_timeout;

    logic              r_clock;
    logic              r_start;
    logic [HC_W-1:0]   r_hc;
    logic [TO_W-1:0]   r_idle;
    logic [TC_W-1:0]   r_tc;
    logic              r_running;
    logic              r_armed;
    logic              r_finished;
    logic              r_timeout_seen;

    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_quo;
    logic [REM_W-1:0]  r_rem;
    logic [IC_W-1:0]   r_dvs;
    logic [PIX_AW-1:0] r_pix;
    logic              r_rd_ok;
    logic [PIXV_W-1:0] r_value;
    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out_data;

    logic [TC_W-1:0]   pix_diff;
    logic              pix_ok;
    logic              tc_above;
    logic              trig_live;
    logic              idx_ok;
    logic              rd_en;
    logic [PIX_AW-1:0] rd_addr;
    logic [PIXV_W-1:0] rd_data;
    logic              ram_we;
    logic [PIX_AW-1:0] wr_addr;
    logic [PIXV_W-1:0] wr_data;
    logic [PIXV_W-1:0] sum;
    logic [REM_W:0]    div_trial;
    logic              div_fit;

    assign tc_above  = (r_tc > TC_W'(r_skip));
    assign pix_diff  = r_tc - TC_W'(r_skip) - TC_W'(1);
    assign pix_ok    = (32'(pix_diff) < 32'(PIXELS));
    assign trig_live = r_running && r_armed;
    assign idx_ok    = (32'(i_pixel_index) < 32'(PIXELS));

    assign o_sts.trig_rmw   = trig_live && tc_above && pix_ok;
    assign o_sts.sweep_last = (r_cnt == CNT_W'(PIXELS - 1));
    assign o_sts.div_last   = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign rd_en   = i_cmd.accept && ((i_kind == KIND_READ) ||
                     ((i_kind == KIND_TRIG) && o_sts.trig_rmw));
    assign rd_addr = (i_kind == KIND_READ) ? PIX_AW'(i_pixel_index) : pix_diff[PIX_AW-1:0];

    assign sum     = rd_data + PIXV_W'(r_quo);
    assign ram_we  = i_cmd.sweep_we || i_cmd.rmw_we;
    assign wr_addr = i_cmd.sweep_we ? r_cnt[PIX_AW-1:0] : r_pix;
    assign wr_data = i_cmd.sweep_we ? '0 : sum;

    assign div_trial = {r_rem, r_quo[DVD_W-1]};
    assign div_fit   = (div_trial >= {1'b0, r_dvs});

    lisr_ram #(
        .WIDTH(PIXV_W),
        .DEPTH(PIXELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_hc <= RST_START_HC;
            r_int_cnt  <= RST_INT_CNT;
            r_skip     <= RST_SKIP;
            r_timeout  <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_HC: r_start_hc <= i_cfg_data;
                CFG_INT_CNT:  r_int_cnt  <= i_cfg_data[IC_W-1:0];
                CFG_SKIP:     r_skip     <= i_cfg_data[SKIP_W-1:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TO_W-1:0];
                default: ;
            endcase
        end
    end

    // acquisition status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock        <= 1'b0;
            r_start        <= 1'b0;
            r_hc           <= '0;
            r_idle         <= '0;
            r_tc           <= '0;
            r_running      <= 1'b0;
            r_armed        <= 1'b0;
            r_finished     <= 1'b0;
            r_timeout_seen <= 1'b0;
        end else if (i_cmd.accept) begin
            unique case (i_kind)
                KIND_START: begin
                    r_clock        <= 1'b0;
                    r_start        <= 1'b1;
                    r_hc           <= '0;
                    r_idle         <= '0;
                    r_tc           <= '0;
                    r_running      <= 1'b1;
                    r_armed        <= 1'b0;
                    r_finished     <= 1'b0;
                    r_timeout_seen <= 1'b0;
                end
                KIND_TICK: begin
                    if (r_running) begin
                        r_clock <= !r_clock;
                        if (!r_armed) begin
                            if (r_hc == r_start_hc) begin
                                r_start <= 1'b0;
                                r_armed <= 1'b1;
                            end else if (r_hc < r_start_hc) begin
                                r_hc <= r_hc + HC_W'(1);
                            end
                        end else if (r_idle != r_timeout) begin
                            r_idle <= r_idle + TO_W'(1);
                        end else begin
                            r_running      <= 1'b0;
                            r_armed        <= 1'b0;
                            r_start        <= 1'b0;
                            r_finished     <= 1'b1;
                            r_timeout_seen <= 1'b1;
                        end
                    end
                end
                KIND_TRIG: begin
                    if (trig_live) begin
                        r_idle <= TO_W'(1);
                        if (tc_above && (r_tc == TC_W'(PIXELS) + TC_W'(r_skip))) begin
                            r_running  <= 1'b0;
                            r_armed    <= 1'b0;
                            r_start    <= 1'b0;
                            r_finished <= 1'b1;
                        end
                        // saturates well above any pixel slot
                        if (r_tc != '1) begin
                            r_tc <= r_tc + TC_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // step counter, divider and result value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= '0;
            r_rd_ok <= idx_ok;
            r_pix   <= pix_diff[PIX_AW-1:0];
            r_quo   <= FULL_SCALE - DVD_W'(i_sample & SAMPLE_MASK);
            r_rem   <= '0;
            r_dvs   <= (r_int_cnt == '0) ? IC_W'(1) : r_int_cnt;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DVD_W-2:0], div_fit};
            r_rem <= div_fit ? REM_W'(div_trial - {1'b0, r_dvs}) : div_trial[REM_W-1:0];
        end else if (i_cmd.take_rd) begin
            r_value <= r_rd_ok ? rd_data : '0;
        end else if (i_cmd.rmw_we) begin
            r_value <= sum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {2'b00, r_value, r_timeout_seen, r_finished, r_running,
                           r_armed, r_start, r_clock};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hw/rtl/linear_image_sensor_readout.sv]
// linear_image_sensor_readout: readout sequencer for a linear image sensor
// depends on lisr_pkg, lisr_ctrl, lisr_dp (which holds lisr_ram)
//
//   channel  direction  signals                     item
//   s        in         i_s_tvalid/o_s_tready       kind in tuser, sample and pixel index
//   m        out        o_m_tvalid/i_m_tready       status flags and pixel value
//   cfg      in         i_cfg_we/i_cfg_idx          one register write per cycle
//
// start, tick and unused kinds go straight to the result, a read reads the store,
// a trigger that lands in a pixel runs the bit-serial divider and writes the sum
// back, a clear sweeps the store (one store word per cycle). after reset the store
// is swept to zero with o_s_tready low. a stalled result holds in the output register;
// the next item is taken meanwhile and waits for that register before it is shown.
module linear_image_sensor_readout
    import lisr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_DW-1:0]  i_s_tdata,   // sample [13:0], pixel_index [24:14]
    input  logic [KIND_W-1:0] i_s_tuser,   // kind [2:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata,   // clock_level, start_level, adc_selected,
                                           // busy_res, done_res, timed_out, pixel_value [21:6]
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    lisr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_kind  (i_s_tuser),
        .o_ready (o_s_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lisr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_s_tuser),
        .i_sample      (i_s_tdata[SMP_W-1:0]),
        .i_pixel_index (i_s_tdata[SMP_W+IDX_W-1:SMP_W]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_out_data    (o_m_tdata)
    );

endmodule

[verif/tb_linear_image_sensor_readout.sv]
// tb_linear_image_sensor_readout: self-checking bench for the sensor readout sequencer
// sends start, tick, trigger, clear and read items and checks every status result
// needs lisr_pkg and linear_image_sensor_readout
module tb_linear_image_sensor_readout
    import lisr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 8;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [PIXV_W-1:0] pixel_value;
        logic              timed_out;
        logic              done_res;
        logic              busy_res;
        logic              adc_selected;
        logic              start_level;
        logic              clock_level;
    } t_readout;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic              cfg_we   = 1'b0;
    logic [CFG_AW-1:0] cfg_idx  = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    int          src_idle_pct  = 33;
    int          sink_idle_pct = 33;
    int          err_cnt       = 0;
    int unsigned cycle_cnt     = 0;
    t_readout    readout_due[$];

    // predictor state
    logic [HC_W-1:0]   cfg_start_hc = RST_START_HC;
    logic [IC_W-1:0]   cfg_integ    = RST_INT_CNT;
    logic [SKIP_W-1:0] cfg_skip     = RST_SKIP;
    logic [TO_W-1:0]   cfg_tmo      = RST_TIMEOUT;
    logic              sck_q   = 1'b0;
    logic              st_q    = 1'b0;
    logic              armed_q = 1'b0;
    logic              run_q   = 1'b0;
    logic              done_q  = 1'b0;
    logic              tmo_q   = 1'b0;
    logic [HC_W-1:0]   half_cnt = '0;
    logic [TO_W-1:0]   idle_cnt = '0;
    int unsigned       trig_cnt = 0;
    logic [PIXV_W-1:0] pixel_mem [PIXELS] = '{default: '0};

    linear_image_sensor_readout u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_linear_image_sensor_readout: done, errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic void close_acq(logic by_timeout);
        run_q   = 1'b0;
        armed_q = 1'b0;
        st_q    = 1'b0;
        done_q  = 1'b1;
        if (by_timeout) begin
            tmo_q = 1'b1;
        end
    endfunction

    function automatic t_readout predict_readout(logic [KIND_W-1:0] kind,
                                                 logic [SMP_W-1:0] smp,
                                                 logic [IDX_W-1:0] idx);
        t_readout    r;
        int unsigned slot;
        int unsigned dvs;
        int unsigned inc;
        r = '0;
        case (kind)
            KIND_START: begin
                sck_q    = 1'b0;
                st_q     = 1'b1;
                half_cnt = '0;
                idle_cnt = '0;
                trig_cnt = 0;
                run_q    = 1'b1;
                armed_q  = 1'b0;
                done_q   = 1'b0;
                tmo_q    = 1'b0;
            end
            KIND_TICK: begin
                if (run_q) begin
                    sck_q = ~sck_q;
                    if (!armed_q) begin
                        if (half_cnt == cfg_start_hc) begin
                            st_q    = 1'b0;
                            armed_q = 1'b1;
                        end else if (half_cnt < cfg_start_hc) begin
                            half_cnt = half_cnt + 1'b1;
                        end
                    end else if (idle_cnt != cfg_tmo) begin
                        idle_cnt = idle_cnt + 1'b1;
                    end else begin
                        close_acq(1'b1);
                    end
                end
            end
            KIND_TRIG: begin
                if (run_q && armed_q) begin
                    idle_cnt = TO_W'(1);
                    if (trig_cnt > cfg_skip) begin
                        slot = trig_cnt - cfg_skip - 1;
                        dvs  = (cfg_integ == '0) ? 1 : cfg_integ;
                        inc  = ((1 << SAMPLE_BITS) - smp) / dvs;
                        if (slot < PIXELS) begin
                            pixel_mem[slot] = pixel_mem[slot] + PIXV_W'(inc);
                            r.pixel_value   = pixel_mem[slot];
                        end
                        if (trig_cnt == PIXELS + cfg_skip) begin
                            close_acq(1'b0);
                        end
                    end
                    trig_cnt++;
                end
            end
            KIND_CLEAR: begin
                foreach (pixel_mem[i]) begin
                    pixel_mem[i] = '0;
                end
            end
            KIND_READ: begin
                r.pixel_value = pixel_mem[idx];
            end
            default: ;
        endcase
        r.clock_level  = sck_q;
        r.start_level  = st_q;
        r.adc_selected = armed_q;
        r.busy_res     = run_q;
        r.done_res     = done_q;
        r.timed_out    = tmo_q;
        return r;
    endfunction

    always @(posedge clk) begin
        t_readout got;
        t_readout want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_readout'(m_tdata[$bits(t_readout)-1:0]);
            if (readout_due.size() == 0) begin
                if (err_cnt < 10) begin
                    $display("unexpected result: tdata %h", m_tdata);
                end
                err_cnt++;
            end else begin
                want = readout_due.pop_front();
                if (got !== want) begin
                    if (err_cnt < 10) begin
                        $display({"mismatch clk/start/adc/busy/done/tmo pix: ",
                                  "got %b%b%b%b%b%b %h, want %b%b%b%b%b%b %h"},
                                 got.clock_level, got.start_level, got.adc_selected,
                                 got.busy_res, got.done_res, got.timed_out, got.pixel_value,
                                 want.clock_level, want.start_level, want.adc_selected,
                                 want.busy_res, want.done_res, want.timed_out,
                                 want.pixel_value);
                    end
                    err_cnt++;
                end
            end
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SMP_W-1:0] smp,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_DW'({idx, smp});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        readout_due.push_back(predict_readout(kind, smp, idx));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (readout_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input logic [HC_W-1:0] start_hc, input logic [IC_W-1:0] integ,
                              input logic [SKIP_W-1:0] skip, input logic [TO_W-1:0] tmo);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_START_HC;
        cfg_data <= CFG_DW'(start_hc);
        @(posedge clk);
        cfg_idx  <= CFG_INT_CNT;
        cfg_data <= CFG_DW'(integ);
        @(posedge clk);
        cfg_idx  <= CFG_SKIP;
        cfg_data <= CFG_DW'(skip);
        @(posedge clk);
        cfg_idx  <= CFG_TIMEOUT;
        cfg_data <= CFG_DW'(tmo);
        @(posedge clk);
        cfg_we       <= 1'b0;
        cfg_start_hc = start_hc;
        cfg_integ    = integ;
        cfg_skip     = skip;
        cfg_tmo      = tmo;
    endtask

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(99) < 70) begin
            return IDX_W'($urandom_range(0, 15));
        end
        return IDX_W'($urandom_range(0, PIXELS - 1));
    endfunction

    task automatic test_idle_items();
        send_item(KIND_READ, pick_sample(), '0);
        send_item(KIND_READ, pick_sample(), '1);
        send_item(KIND_TICK, pick_sample(), pick_index());
        send_item(KIND_TRIG, '1, pick_index());
        send_item(KIND_CLEAR, pick_sample(), pick_index());
        send_item(KIND_SPARE_HI, pick_sample(), pick_index());
    endtask

    task automatic test_acquisition();
        set_config(16'd2, '0, 8'd1, 10'd3);
        send_item(KIND_START, pick_sample(), pick_index());
        send_item(KIND_TRIG, pick_sample(), pick_index());
        repeat (3) send_item(KIND_TICK, pick_sample(), pick_index());
        send_item(KIND_TRIG, '1, pick_index());
        send_item(KIND_TRIG, '0, pick_index());
        send_item(KIND_TRIG, '0, pick_index());
        send_item(KIND_TRIG, '1, pick_index());
        send_item(KIND_TRIG, pick_sample(), pick_index());
        send_item(KIND_READ, pick_sample(), IDX_W'(0));
        send_item(KIND_READ, pick_sample(), IDX_W'(1));
        // restart mid-acquisition keeps the store
        send_item(KIND_START, pick_sample(), pick_index());
        repeat (3) send_item(KIND_TICK, pick_sample(), pick_index());
        send_item(KIND_TRIG, pick_sample(), pick_index());
        send_item(KIND_TRIG, pick_sample(), pick_index());
        repeat (4) send_item(KIND_TICK, pick_sample(), pick_index());
        send_item(KIND_TRIG, pick_sample(), pick_index());
        send_item(KIND_READ, pick_sample(), IDX_W'(0));
    endtask

    task automatic test_full_frame();
        set_config('0, 8'd1, '1, '1);
        send_item(KIND_START, pick_sample(), pick_index());
        send_item(KIND_TICK, pick_sample(), pick_index());
        repeat (PIXELS + 256) send_item(KIND_TRIG, pick_sample(), pick_index());
        send_item(KIND_TRIG, pick_sample(), pick_index());
        send_item(KIND_READ, pick_sample(), '1);
        send_item(KIND_READ, pick_sample(), '0);
    endtask

    task automatic run_random_phase(input int n_items, input int tick_pct);
        logic [KIND_W-1:0] kind;
        int                roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end else if (roll < 4) begin
                kind = KIND_CLEAR;
            end else if (roll < 10) begin
                kind = KIND_READ;
            end else if (roll < 13 || !run_q) begin
                kind = KIND_START;
            end else if (!armed_q) begin
                kind = ($urandom_range(99) < 85) ? KIND_TICK : KIND_TRIG;
            end else begin
                kind = ($urandom_range(99) < tick_pct) ? KIND_TICK : KIND_TRIG;
            end
            send_item(kind, pick_sample(), pick_index());
        end
    endtask

    task automatic test_random_acquisitions();
        int tick_pct;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config('0, '0, '0, '0);
                1: set_config('1, '1, '1, '1);
                2: set_config(16'd1, '1, '0, 10'd1);
                default: set_config(HC_W'($urandom_range(0, 10)), IC_W'($urandom_range(1, 255)),
                                    SKIP_W'($urandom_range(0, 6)), TO_W'($urandom_range(1, 12)));
            endcase
            case ($urandom_range(2))
                0: tick_pct = 15;
                1: tick_pct = 40;
                default: tick_pct = 75;
            endcase
            // one calm stretch with both sides always ready
            src_idle_pct  = (p == 4) ? 0 : 33;
            sink_idle_pct = (p == 4) ? 0 : 33;
            run_random_phase((p == 1) ? 60 : 190, tick_pct);
        end
        src_idle_pct  = 33;
        sink_idle_pct = 33;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_items();
        test_acquisition();
        test_full_frame();
        test_random_acquisitions();
        wait_drained();
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && readout_due.size() == 0) begin
            $display("tb_linear_image_sensor_readout: done, clean");
        end else begin
            $display("tb_linear_image_sensor_readout: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lisr_pkg.sv
hw/rtl/lisr_ram.sv
hw/rtl/lisr_ctrl.sv
hw/rtl/lisr_dp.sv
hw/rtl/linear_image_sensor_readout.sv
verif/tb_linear_image_sensor_readout.sv
